>>> src/lpkt_pkg.sv
// shared definitions for the linear probe keyword table
// result codes, default sizes and the controller/datapath command and status words
// no dependencies
package lpkt_pkg;

    localparam int unsigned TABLE_SIZE_DEF = 977;
    localparam int unsigned KEY_BYTES_DEF  = 8;

    localparam int unsigned SLOT_W  = 12;
    localparam int unsigned TYPE_W  = 16;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned HDL_W   = 16;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    take_in;    // latch the input word and its hash
        logic    load_home;  // probe pointer to the home slot
        logic    rd_en;      // read the slot under the probe pointer
        logic    step_pos;   // advance the probe pointer with wrap
        logic    clr_write;  // clear the slot under the pointer
        logic    load_out;   // fill the output register
        t_status res;        // result code for load_out
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic rd_valid;    // slot just read is occupied
        logic key_match;   // slot just read holds the key
        logic probe_last;  // every slot has been visited
        logic pos_last;    // pointer at the top slot
        logic table_full;  // one more entry would fill the table
        logic is_lookup;   // current word is a lookup
    } t_dp_stat;

endpackage

>>> src/lpkt_ctrl.sv
// sequencing state machine of the keyword table
// drives datapath commands, the input stall and the output valid
// depends on lpkt_pkg
module lpkt_ctrl
    import lpkt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_RED,
        S_HOME,
        S_READ,
        S_CHECK
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid;
    logic    w_out_free;
    t_dp_cmd w_cmd;

    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.clr_write = 1'b1;
                w_cmd.step_pos  = 1'b1;
                if (i_stat.pos_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    w_cmd.take_in = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL:  n_state = S_RED;
            S_RED:  n_state = S_HOME;
            S_HOME: begin
                w_cmd.load_home = 1'b1;
                n_state         = S_READ;
            end
            S_READ: begin
                w_cmd.rd_en = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.rd_valid && !i_stat.key_match && !i_stat.probe_last) begin
                    w_cmd.step_pos = 1'b1;
                    n_state        = S_READ;
                end else if (w_out_free) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                    priority if (i_stat.rd_valid && i_stat.key_match) begin
                        w_cmd.res = ST_FOUND;
                    end else if (i_stat.is_lookup) begin
                        w_cmd.res = ST_NOT_FOUND;
                    end else if (i_stat.rd_valid || i_stat.table_full) begin
                        // whole table probed or no room left
                        w_cmd.res = ST_OVERFLOW;
                    end else begin
                        w_cmd.res = ST_INSERTED;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.load_out) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_cmd   = w_cmd;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> src/lpkt_dp.sv
// datapath of the keyword table: key normalising, home slot reduction,
// entry memory, probe pointer, occupancy count and output register
// depends on lpkt_pkg
module lpkt_dp
    import lpkt_pkg::*;
#(
    parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int unsigned KEY_BYTES  = KEY_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    input  logic                      i_mode,
    input  logic [63:0]               i_key,
    input  logic [TYPE_W-1:0]         i_entry_type,
    input  logic signed [VALUE_W-1:0] i_entry_value,
    input  logic [HDL_W-1:0]          i_handler_id,
    output logic [1:0]                o_status,
    output logic [SLOT_W-1:0]         o_slot,
    output logic [TYPE_W-1:0]         o_out_type,
    output logic signed [VALUE_W-1:0] o_out_value,
    output logic [HDL_W-1:0]          o_out_handler
);

    localparam int unsigned KEY_W = 8 * KEY_BYTES;
    localparam int unsigned SUM_W = $clog2(KEY_BYTES * 255 + 1);
    localparam int unsigned POS_W = $clog2(TABLE_SIZE);
    localparam int unsigned REM_W = POS_W + 1;
    localparam int unsigned QT_W  = SUM_W + POS_W + 1;
    localparam int unsigned PRD_W = 2 * SUM_W;
    // floor(2^SUM_W / size): quotient estimate is exact or one low
    localparam logic [SUM_W-1:0] RECIP = SUM_W'((1 << SUM_W) / TABLE_SIZE);

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [TYPE_W-1:0]  etype;
        logic [VALUE_W-1:0] value;
        logic [HDL_W-1:0]   handler;
    } t_entry;

    t_entry mem [TABLE_SIZE];
    t_entry r_rd;
    t_entry w_new;

    logic [KEY_W-1:0]   w_key_norm;
    logic [SUM_W-1:0]   w_sum;
    logic               w_alive;

    logic               r_mode;
    logic [KEY_W-1:0]   r_key;
    logic [SUM_W-1:0]   r_sum;
    logic [TYPE_W-1:0]  r_type;
    logic [VALUE_W-1:0] r_value;
    logic [HDL_W-1:0]   r_handler;

    logic [PRD_W-1:0]   w_prod;
    logic [SUM_W-1:0]   r_q;
    logic [QT_W-1:0]    w_qt;
    logic [REM_W-1:0]   r_rem;
    logic [POS_W-1:0]   w_home;

    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_probe;
    logic [POS_W-1:0]   r_used;
    logic               w_pos_last;
    logic               w_ins;

    logic [1:0]         r_out_status;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [TYPE_W-1:0]  r_out_type;
    logic [VALUE_W-1:0] r_out_value;
    logic [HDL_W-1:0]   r_out_handler;

    // key ends at its first zero byte
    always_comb begin
        w_key_norm = '0;
        w_sum      = '0;
        w_alive    = 1'b1;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (i_key[8*b +: 8] == 8'd0) w_alive = 1'b0;
            if (w_alive) begin
                w_key_norm[8*b +: 8] = i_key[8*b +: 8];
                w_sum                = w_sum + SUM_W'(i_key[8*b +: 8]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_mode    <= i_mode;
            r_key     <= w_key_norm;
            r_sum     <= w_sum;
            r_type    <= i_entry_type;
            r_value   <= $unsigned(i_entry_value);
            r_handler <= i_handler_id;
        end
    end

    // sum mod size by reciprocal, two registered steps then one correction
    assign w_prod = PRD_W'(r_sum) * PRD_W'(RECIP);
    assign w_qt   = QT_W'(r_q) * QT_W'(TABLE_SIZE);
    assign w_home = (r_rem >= REM_W'(TABLE_SIZE)) ? POS_W'(r_rem - REM_W'(TABLE_SIZE))
                                                  : POS_W'(r_rem);

    always_ff @(posedge i_clk) begin
        r_q   <= w_prod[PRD_W-1:SUM_W];
        r_rem <= REM_W'(QT_W'(r_sum) - w_qt);
    end

    assign w_pos_last = (r_pos == POS_W'(TABLE_SIZE - 1));
    assign w_ins      = i_cmd.load_out && (i_cmd.res == ST_INSERTED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_used <= '0;
        end else begin
            if (i_cmd.load_home) r_pos <= w_home;
            else if (i_cmd.step_pos) r_pos <= w_pos_last ? '0 : r_pos + 1'b1;
            if (w_ins) r_used <= r_used + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_home) r_probe <= '0;
        else if (i_cmd.step_pos) r_probe <= r_probe + 1'b1;
    end

    always_comb begin
        w_new.valid   = 1'b1;
        w_new.key     = r_key;
        w_new.etype   = r_type;
        w_new.value   = r_value;
        w_new.handler = r_handler;
    end

    // entry memory, one port written and read at the probe pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_write) mem[r_pos] <= '0;
        else if (w_ins) mem[r_pos] <= w_new;
        if (i_cmd.rd_en) r_rd <= mem[r_pos];
    end

    always_comb begin
        o_stat.rd_valid   = r_rd.valid;
        o_stat.key_match  = (r_rd.key == r_key);
        o_stat.probe_last = (r_probe == POS_W'(TABLE_SIZE - 1));
        o_stat.pos_last   = w_pos_last;
        o_stat.table_full = ((REM_W'(r_used) + 1'b1) >= REM_W'(TABLE_SIZE));
        o_stat.is_lookup  = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.res;
            unique case (i_cmd.res)
                ST_FOUND: begin
                    r_out_slot    <= SLOT_W'(r_pos);
                    r_out_type    <= r_rd.etype;
                    r_out_value   <= r_rd.value;
                    r_out_handler <= r_rd.handler;
                end
                ST_INSERTED: begin
                    r_out_slot    <= SLOT_W'(r_pos);
                    r_out_type    <= r_type;
                    r_out_value   <= r_value;
                    r_out_handler <= r_handler;
                end
                default: begin
                    r_out_slot    <= '0;
                    r_out_type    <= '0;
                    r_out_value   <= '0;
                    r_out_handler <= '0;
                end
            endcase
        end
    end

    assign o_status      = r_out_status;
    assign o_slot        = r_out_slot;
    assign o_out_type    = r_out_type;
    assign o_out_value   = $signed(r_out_value);
    assign o_out_handler = r_out_handler;

endmodule

>>> src/linear_probe_keyword_table.sv
// top level of the linear probe keyword table
// joins the lpkt_ctrl state machine and the lpkt_dp datapath
// depends on lpkt_pkg, lpkt_ctrl, lpkt_dp
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+---------------------------------------------
//  request | in        | i_valid / o_stall  | mode, key, entry_type, entry_value, handler_id
//  result  | out       | o_valid / i_stall  | status, slot, out_type, out_value, out_handler
//
// a request passes the MUL, RED and HOME states, then READ and CHECK once for each
// slot probed; the loop is set by the single port entry memory read and the
// compare (read, then check)
// after reset a clearing pass over every slot empties the table; o_stall
// is high during it
// one request is in flight at a time; o_stall is low only while idle
// the result register frees the input side: a new request is taken while the
// previous result still waits under i_stall
module linear_probe_keyword_table
    import lpkt_pkg::*;
#(
    parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,  // 2 to 4096 slots
    parameter int unsigned KEY_BYTES  = KEY_BYTES_DEF    // 1 to 8 key bytes
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_mode,
    input  logic [63:0]               i_key,
    input  logic [TYPE_W-1:0]         i_entry_type,
    input  logic signed [VALUE_W-1:0] i_entry_value,
    input  logic [HDL_W-1:0]          i_handler_id,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_status,
    output logic [SLOT_W-1:0]         o_slot,
    output logic [TYPE_W-1:0]         o_out_type,
    output logic signed [VALUE_W-1:0] o_out_value,
    output logic [HDL_W-1:0]          o_out_handler
);

    // command and status words between the two halves
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // state machine: clearing pass, hash wait, probe loop, result hand-off
    lpkt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    // datapath: key normalising, modulo reduction, entry memory, result register
    lpkt_dp #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BYTES  (KEY_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_entry_type  (i_entry_type),
        .i_entry_value (i_entry_value),
        .i_handler_id  (i_handler_id),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_out_type    (o_out_type),
        .o_out_value   (o_out_value),
        .o_out_handler (o_out_handler)
    );

endmodule

>>> test/tb_top.sv
// self-checking testbench for linear_probe_keyword_table
// a directed table of requests, then random inserts and lookups, checked against a local predictor
// depends on lpkt_pkg and linear_probe_keyword_table
module tb_top;
    import lpkt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TBL = TABLE_SIZE_DEF;

    // request modes as the block decodes them
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // random part: a mixed phase, a top-up to a full table, then a tail on the full table
    localparam int unsigned MIXED_WORDS = 1450;
    localparam int unsigned TAIL_WORDS  = 120;

    // worst case per request is a probe walk over every slot plus the random gap
    // on each side; for ~1800 requests the limit below leaves ample margin
    localparam int unsigned CYCLE_LIMIT = 16_000_000;

    // one long hold-off on the result side, in cycles, taken at these result counts
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned HOLD_AT_A = 150;
    localparam int unsigned HOLD_AT_B = 1000;

    // longest single request, used for the quiet tail at the end of the run
    localparam int unsigned DRAIN_CYCLES = 5 + 2 * TBL;

    typedef struct packed {
        t_status                  status;
        logic [SLOT_W-1:0]        slot;
        logic [TYPE_W-1:0]        typ;
        logic signed [VALUE_W-1:0] value;
        logic [HDL_W-1:0]         handler;
    } t_table_reply;

    // one row of the directed table; typed rows carry their expected reply
    typedef struct packed {
        logic                mode;
        logic [63:0]         key;
        logic [TYPE_W-1:0]   typ;
        logic [VALUE_W-1:0]  value;
        logic [HDL_W-1:0]    handler;
        logic                typed;
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [TYPE_W-1:0]   o_typ;
        logic [VALUE_W-1:0]  o_value;
        logic [HDL_W-1:0]    o_handler;
    } t_plan_row;

    typedef enum int {
        ADD_NEW,
        ADD_KNOWN,
        FIND_KNOWN,
        FIND_NEW,
        RAW_NOISE
    } t_req_kind;

    localparam int unsigned PLAN_ROWS = 20;

    // home slot of a key is its byte sum modulo TBL: 0x41 -> 65, all ones -> 2040 -> 86,
    // 0xD3FFFFFF -> 976 (top slot), 0xD4FFFFFF -> 977 -> 0
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        // lookup on the empty table
        '{OP_LOOKUP, 64'h41, 16'h0, 32'h0, 16'h0,
          1'b1, ST_NOT_FOUND, 12'd0, 16'h0, 32'h0, 16'h0},
        // first insert, field maxima
        '{OP_INSERT, 64'h41, 16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF,
          1'b1, ST_INSERTED, 12'd65, 16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF},
        // same key again: the old entry comes back, new fields ignored
        '{OP_INSERT, 64'h41, 16'h0001, 32'h0000_0001, 16'h0001,
          1'b1, ST_FOUND, 12'd65, 16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF},
        // bytes above the terminating zero are ignored
        '{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_0041, 16'h0, 32'h0, 16'h0,
          1'b1, ST_FOUND, 12'd65, 16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF},
        // empty key is a key of its own, field minima
        '{OP_INSERT, 64'h0, 16'h0000, 32'h8000_0000, 16'h0000,
          1'b1, ST_INSERTED, 12'd0, 16'h0000, 32'h8000_0000, 16'h0000},
        '{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 16'h0, 32'h0, 16'h0,
          1'b1, ST_FOUND, 12'd0, 16'h0000, 32'h8000_0000, 16'h0000},
        // all-ones key, largest byte sum
        '{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h1234, 32'hFFFF_FFFF, 16'h8000,
          1'b1, ST_INSERTED, 12'd86, 16'h1234, 32'hFFFF_FFFF, 16'h8000},
        // three keys on home slot 66, a hit on the third, then a miss that walks past the last two
        '{OP_INSERT, 64'h42, 16'h00A5, 32'h5A5A_5A5A, 16'h5A5A,
          1'b0, ST_FOUND, 12'd0, 16'h0, 32'h0, 16'h0},
        '{OP_INSERT, 64'h0141, 16'hA500, 32'hA5A5_A5A5, 16'hA5A5,
          1'b0, ST_FOUND, 12'd0, 16'h0, 32'h0, 16'h0},
        '{OP_INSERT, 64'h4101, 16'h0F0F, 32'h0F0F_0F0F, 16'hF0F0,
          1'b0, ST_FOUND, 12'd0, 16'h0, 32'h0, 16'h0},
        '{OP_LOOKUP, 64'h4101, 16'h0, 32'h0, 16'h0,
          1'b0, ST_FOUND, 12'd0, 16'h0, 32'h0, 16'h0},
        '{OP_LOOKUP, 64'h0241, 16'h0, 32'h0, 16'h0,
          1'b0, ST_FOUND, 12'd0, 16'h0, 32'h0, 16'h0},
        // top slot, then wrap round to slot 0 and beyond
        '{OP_INSERT, 64'hD3FF_FFFF, 16'h7777, 32'h1234_5678, 16'h0777,
          1'b0, ST_FOUND, 12'd0, 16'h0, 32'h0, 16'h0},
        '{OP_INSERT, 64'hFFFF_FFD3, 16'h8888, 32'h8765_4321, 16'h0888,
          1'b0, ST_FOUND, 12'd0, 16'h0, 32'h0, 16'h0},
        '{OP_LOOKUP, 64'hFFD3_FFFF, 16'h0, 32'h0, 16'h0,
          1'b0, ST_FOUND, 12'd0, 16'h0, 32'h0, 16'h0},
        '{OP_INSERT, 64'hD4FF_FFFF, 16'h4444, 32'hC000_0001, 16'h4444,
          1'b0, ST_FOUND, 12'd0, 16'h0, 32'h0, 16'h0},
        '{OP_LOOKUP, 64'hFFFF_FFD3, 16'h0, 32'h0, 16'h0,
          1'b0, ST_FOUND, 12'd0, 16'h0, 32'h0, 16'h0},
        '{OP_INSERT, 64'h0101_0101_0101_0101, 16'h8000, 32'h0000_0000, 16'h0001,
          1'b0, ST_FOUND, 12'd0, 16'h0, 32'h0, 16'h0},
        '{OP_LOOKUP, 64'hFF, 16'h0, 32'h0, 16'h0,
          1'b0, ST_FOUND, 12'd0, 16'h0, 32'h0, 16'h0},
        // insert on a key whose first byte is zero finds the empty key
        '{OP_INSERT, 64'h8000_0000_0000_0000, 16'hBEEF, 32'h1111_1111, 16'hBEEF,
          1'b0, ST_FOUND, 12'd0, 16'h0, 32'h0, 16'h0}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic                      i_mode;
    logic [63:0]               i_key;
    logic [TYPE_W-1:0]         i_entry_type;
    logic signed [VALUE_W-1:0] i_entry_value;
    logic [HDL_W-1:0]          i_handler_id;
    logic                      o_valid;
    logic                      i_stall;
    logic [1:0]                o_status;
    logic [SLOT_W-1:0]         o_slot;
    logic [TYPE_W-1:0]         o_out_type;
    logic signed [VALUE_W-1:0] o_out_value;
    logic [HDL_W-1:0]          o_out_handler;

    // predictor copy of the table
    bit                   slot_used    [TBL];
    logic [63:0]          slot_key     [TBL];
    logic [TYPE_W-1:0]    slot_type    [TBL];
    logic [VALUE_W-1:0]   slot_value   [TBL];
    logic [HDL_W-1:0]     slot_handler [TBL];
    int unsigned          entry_count = 0;

    logic [63:0]   known_keys [$];        // trimmed keys held in the table
    t_table_reply  pending_replies [$];   // replies still owed by the block, oldest first

    int unsigned error_count   = 0;
    int unsigned replies_taken = 0;
    int unsigned cycle_count   = 0;
    bit          send_quiet    = 1'b0;
    bit          take_quiet    = 1'b0;

    linear_probe_keyword_table uut (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog: a lost or stuck word ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // keep the bytes below the first zero byte and add them up
    function automatic logic [63:0] trim_key(input logic [63:0] raw,
                                             output int unsigned byte_sum);
        logic [63:0] kept;
        bit          ended;
        int          i;
        kept     = '0;
        byte_sum = 0;
        ended    = 1'b0;
        for (i = 0; i < KEY_BYTES_DEF; i++) begin
            if (raw[8*i +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended) begin
                kept[8*i +: 8] = raw[8*i +: 8];
                byte_sum += raw[8*i +: 8];
            end
        end
        return kept;
    endfunction

    // predictor: probe from the home slot, update the table copy, return the reply
    function automatic t_table_reply probe_table(input logic mode, input logic [63:0] raw,
                                                 input logic [TYPE_W-1:0] typ,
                                                 input logic [VALUE_W-1:0] value,
                                                 input logic [HDL_W-1:0] handler);
        t_table_reply reply;
        logic [63:0]  k;
        int unsigned  sum, pos, n;
        bit           hit, hole;
        k     = trim_key(raw, sum);
        pos   = sum % TBL;
        hit   = 1'b0;
        hole  = 1'b0;
        n     = 0;
        reply = '0;
        reply.status = ST_NOT_FOUND;
        while (n < TBL && !hit && !hole) begin
            if (!slot_used[pos])
                hole = 1'b1;
            else if (slot_key[pos] == k)
                hit = 1'b1;
            else begin
                pos = (pos + 1 >= TBL) ? 0 : pos + 1;
                n++;
            end
        end
        if (hit) begin
            reply.status = ST_FOUND;
        end else if (mode == OP_LOOKUP) begin
            return reply;
        end else if (!hole || entry_count + 1 >= TBL) begin
            // one slot always stays free, so the table reports overflow instead
            reply.status = ST_OVERFLOW;
            return reply;
        end else begin
            entry_count++;
            slot_used[pos]    = 1'b1;
            slot_key[pos]     = k;
            slot_type[pos]    = typ;
            slot_value[pos]   = value;
            slot_handler[pos] = handler;
            known_keys.push_back(k);
            reply.status = ST_INSERTED;
        end
        reply.slot    = pos[SLOT_W-1:0];
        reply.typ     = slot_type[pos];
        reply.value   = slot_value[pos];
        reply.handler = slot_handler[pos];
        return reply;
    endfunction

    // put random garbage above the terminating zero byte, half the time when the key is short enough
    function automatic logic [63:0] dress_key(input logic [63:0] k);
        int unsigned len;
        logic [63:0] junk;
        len = 0;
        while (len < 8 && k[8*len +: 8] != 8'h00)
            len++;
        junk = {$urandom, $urandom};
        if (len < 7 && $urandom_range(0, 1))
            return k | (junk << (8 * (len + 1)));
        return k;
    endfunction

    // fresh key with a byte sum chosen so that home slots spread evenly over the table
    function automatic logic [63:0] make_key();
        logic [63:0] k;
        int unsigned s, len, lo, hi, rem, left, b, i;
        k = '0;
        s = $urandom_range(0, TBL - 1);
        if (s == 0 || $urandom_range(0, 1))
            s += TBL;
        lo  = (s + 254) / 255;
        hi  = (s < 8) ? s : 8;
        len = $urandom_range(hi, lo);
        rem = s;
        for (i = 0; i < len; i++) begin
            left = len - 1 - i;
            lo   = (rem > 255 * left) ? rem - 255 * left : 1;
            hi   = (rem - left > 255) ? 255 : rem - left;
            b    = $urandom_range(hi, lo);
            k[8*i +: 8] = b[7:0];
            rem -= b;
        end
        return dress_key(k);
    endfunction

    function automatic logic [63:0] pick_known();
        return dress_key(known_keys[$urandom_range(0, known_keys.size() - 1)]);
    endfunction

    // per-word pause, with stretches of back-to-back words
    function automatic int unsigned pick_pause(inout bit quiet);
        if ($urandom_range(0, 99) < 3)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic t_req_kind pick_kind(input bit full);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (known_keys.size() == 0)
            return ADD_NEW;
        if (!full) begin
            if (r < 55) return ADD_NEW;
            if (r < 68) return ADD_KNOWN;
            if (r < 82) return FIND_KNOWN;
            if (r < 92) return FIND_NEW;
            return RAW_NOISE;
        end
        // on a full table new keys overflow or miss after a long walk
        if (r < 35) return ADD_NEW;
        if (r < 60) return ADD_KNOWN;
        if (r < 85) return FIND_KNOWN;
        return FIND_NEW;
    endfunction

    // offer one request word after a random gap; returns at the falling edge after acceptance
    task automatic drive_word(input logic mode, input logic [63:0] key,
                              input logic [TYPE_W-1:0] typ, input logic [VALUE_W-1:0] value,
                              input logic [HDL_W-1:0] handler);
        int unsigned gap;
        gap = pick_pause(send_quiet);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_mode        = mode;
        i_key         = key;
        i_entry_type  = typ;
        i_entry_value = value;
        i_handler_id  = handler;
        do
            @(posedge i_clk);
        while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic issue(input logic mode, input logic [63:0] key,
                         input logic [TYPE_W-1:0] typ, input logic [VALUE_W-1:0] value,
                         input logic [HDL_W-1:0] handler);
        pending_replies.push_back(probe_table(mode, key, typ, value, handler));
        drive_word(mode, key, typ, value, handler);
    endtask

    task automatic random_word(input t_req_kind kind);
        logic        m;
        logic [63:0] k;
        case (kind)
            ADD_NEW: begin
                m = OP_INSERT;
                k = make_key();
            end
            ADD_KNOWN: begin
                m = OP_INSERT;
                k = pick_known();
            end
            FIND_KNOWN: begin
                m = OP_LOOKUP;
                k = pick_known();
            end
            FIND_NEW: begin
                m = OP_LOOKUP;
                k = make_key();
            end
            default: begin
                // raw 64-bit key; these bunch up around one home slot
                m = 1'($urandom_range(0, 1));
                k = {$urandom, $urandom};
            end
        endcase
        issue(m, k, TYPE_W'($urandom_range(0, 65535)), $urandom,
              HDL_W'($urandom_range(0, 65535)));
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // request side: reset, directed table, then random words
    initial begin : request_side
        int unsigned  n, tries;
        t_plan_row    row;
        t_table_reply want;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_mode        = OP_INSERT;
        i_key         = '0;
        i_entry_type  = '0;
        i_entry_value = '0;
        i_handler_id  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // the clearing pass after reset shows as o_stall, so the first word simply waits

        for (n = 0; n < PLAN_ROWS; n++) begin
            row  = PLAN[n];
            want = probe_table(row.mode, row.key, row.typ, row.value, row.handler);
            if (row.typed) begin
                want.status  = row.status;
                want.slot    = row.slot;
                want.typ     = row.o_typ;
                want.value   = row.o_value;
                want.handler = row.o_handler;
            end
            pending_replies.push_back(want);
            drive_word(row.mode, row.key, row.typ, row.value, row.handler);
        end

        for (n = 0; n < MIXED_WORDS; n++)
            random_word(pick_kind(entry_count + 1 >= TBL));

        // top up to the largest occupancy the table allows
        tries = 0;
        while (entry_count + 1 < TBL && tries < 3000) begin
            random_word(ADD_NEW);
            tries++;
        end

        for (n = 0; n < TAIL_WORDS; n++)
            random_word(pick_kind(entry_count + 1 >= TBL));
        i_valid = 1'b0;

        while (pending_replies.size() != 0)
            @(posedge i_clk);
        // room for a stray extra word to show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // result side: random stall per word, two long hold-offs to back the block up
    initial begin : result_side
        int unsigned  hold;
        t_table_reply want;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = pick_pause(take_quiet);
            if (replies_taken == HOLD_AT_A || replies_taken == HOLD_AT_B)
                hold = LONG_HOLD;
            if (hold > 0) begin
                i_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall = 1'b0;
            do
                @(posedge i_clk);
            while (!o_valid);
            replies_taken++;
            if (pending_replies.size() == 0) begin
                $error("result word with no request waiting: status %0d slot %0d",
                       o_status, o_slot);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                check_field("status", want.status, o_status);
                check_field("slot", want.slot, o_slot);
                check_field("out_type", want.typ, o_out_type);
                check_field("out_value", want.value, o_out_value);
                check_field("out_handler", want.handler, o_out_handler);
            end
            @(negedge i_clk);
        end
    end

endmodule
